// ===== hw/rtl/bta_pkg.sv =====
`default_nettype none

package bta_pkg;

	// Field widths
	localparam int VALUE_W      = 32;
	localparam int OP_W         = 3;
	localparam int CHAR_W       = 7;
	localparam int DIGIT_W      = 4;
	localparam int DIGITS_MAX   = 10;
	localparam int BCD_W        = DIGITS_MAX * DIGIT_W;
	localparam int CNT_W        = 4;
	localparam int DABBLE_STEPS = 8;
	localparam int DABBLE_STAGES = VALUE_W / DABBLE_STEPS;

	localparam logic [CNT_W-1:0]  NDIG_MAX   = CNT_W'(DIGITS_MAX);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_A    = 7'h61;
	localparam logic [CHAR_W-1:0] TEN        = 7'd10;

	// Format codes
	typedef enum logic [OP_W-1:0] {
		OP_BYTE_DEC  = 3'd0,
		OP_WORD_DEC  = 3'd1,
		OP_DWORD_DEC = 3'd2,
		OP_BYTE_HEX  = 3'd3,
		OP_WORD_HEX  = 3'd4,
		OP_DWORD_HEX = 3'd5
	} op_t;

	// Item traveling down the conversion pipeline
	typedef struct packed {
		logic               is_hex;
		logic [CNT_W-1:0]   ndig;
		logic [VALUE_W-1:0] bin;
		logic [BCD_W-1:0]   bcd;
	} dig_item_t;

	// ASCII of one digit, lower-case hex
	function automatic logic [CHAR_W-1:0] ascii_of_digit(logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {3'b000, d};
		if (d < 4'd10) begin
			return ASCII_ZERO + dx;
		end
		return ASCII_A + dx - TEN;
	endfunction

	// Eight shift-add-3 steps of the binary to BCD conversion
	function automatic dig_item_t dabble_steps(dig_item_t it);
		dig_item_t          r;
		logic [BCD_W-1:0]   b;
		logic [VALUE_W-1:0] v;
		b = it.bcd;
		v = it.bin;
		for (int s = 0; s < DABBLE_STEPS; s++) begin
			for (int k = 0; k < DIGITS_MAX; k++) begin
				if (b[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
					b[k*DIGIT_W +: DIGIT_W] = b[k*DIGIT_W +: DIGIT_W] + 4'd3;
				end
			end
			{b, v} = {b[BCD_W-2:0], v, 1'b0};
		end
		r = it;
		r.bcd = b;
		r.bin = v;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/binary_to_ascii_digits.sv =====
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: op; tdata: value
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: character; tlast: last
//
// Path: an item passes the decode register, four 8-bit conversion stages and the output
// register; decode loads at the edge that takes the item.
// Rate: one character per cycle while m_axis_tready is high; an item gives 2 to 10 characters
// (its digit count), shifted out one per cycle by the output register.
// Codes 6 and 7 are taken and give no characters.
// Reset clears all valid bits; payload registers are not reset.
// A low m_axis_tready holds the character and back-pressure moves up the stages.

module binary_to_ascii_digits (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] value
	input  wire logic [2:0]  s_axis_tuser,  // [2:0] op
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [6:0] character, [7] zero
	output logic             m_axis_tlast
);
	import bta_pkg::*;

	logic              stg_valid [DABBLE_STAGES+1];
	logic              stg_ready [DABBLE_STAGES+1];
	dig_item_t         stg_item  [DABBLE_STAGES+1];
	logic [CHAR_W-1:0] character;

	// Decode and mask
	bta_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.op        (s_axis_tuser),
		.value     (s_axis_tdata[VALUE_W-1:0]),
		.out_valid (stg_valid[0]),
		.out_ready (stg_ready[0]),
		.out_item  (stg_item[0])
	);

	// Binary to BCD, eight bits per stage
	for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
		bta_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[g]),
			.in_ready  (stg_ready[g]),
			.in_item   (stg_item[g]),
			.out_valid (stg_valid[g+1]),
			.out_ready (stg_ready[g+1]),
			.out_item  (stg_item[g+1])
		);
	end

	// Character output
	bta_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[DABBLE_STAGES]),
		.in_ready  (stg_ready[DABBLE_STAGES]),
		.in_item   (stg_item[DABBLE_STAGES]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.character (character),
		.last      (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, character};

endmodule

`default_nettype wire

// ===== hw/rtl/bta_front.sv =====
`default_nettype none

module bta_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [bta_pkg::OP_W-1:0]    op,
	input  wire logic [bta_pkg::VALUE_W-1:0] value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output bta_pkg::dig_item_t               out_item
);
	import bta_pkg::*;

	logic      valid_s1;
	dig_item_t item_s1;
	dig_item_t item_d;
	logic      op_ok;

	// Decode the code, mask the value, seed the digit field
	always_comb begin
		item_d = '0;
		op_ok  = 1'b1;
		case (op)
			OP_BYTE_DEC: begin
				item_d.ndig = 4'd3;
				item_d.bin  = {24'd0, value[7:0]};
			end
			OP_WORD_DEC: begin
				item_d.ndig = 4'd5;
				item_d.bin  = {16'd0, value[15:0]};
			end
			OP_DWORD_DEC: begin
				item_d.ndig = 4'd10;
				item_d.bin  = value;
			end
			OP_BYTE_HEX: begin
				item_d.is_hex = 1'b1;
				item_d.ndig   = 4'd2;
				item_d.bcd    = {32'd0, value[7:0]};
			end
			OP_WORD_HEX: begin
				item_d.is_hex = 1'b1;
				item_d.ndig   = 4'd4;
				item_d.bcd    = {24'd0, value[15:0]};
			end
			OP_DWORD_HEX: begin
				item_d.is_hex = 1'b1;
				item_d.ndig   = 4'd8;
				item_d.bcd    = {8'd0, value};
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	// Unused codes are taken and dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && op_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/bta_dabble_stage.sv =====
`default_nettype none

module bta_dabble_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bta_pkg::dig_item_t in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bta_pkg::dig_item_t      out_item
);
	import bta_pkg::*;

	logic      valid_q;
	dig_item_t item_q;
	dig_item_t item_d;

	// Hex items already hold their nibbles and pass unchanged
	always_comb begin
		if (in_item.is_hex) begin
			item_d = in_item;
		end else begin
			item_d = dabble_steps(in_item);
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= item_d;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bta_serializer.sv =====
`default_nettype none

module bta_serializer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire bta_pkg::dig_item_t         in_item,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [bta_pkg::CHAR_W-1:0]      character,
	output logic                            last
);
	import bta_pkg::*;

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BCD_W-1:0]   dig_q;
	logic [CNT_W-1:0]   gap;
	logic [BCD_W-1:0]   aligned;
	logic               take;

	// Move the leading digit to the top nibble
	assign gap     = NDIG_MAX - in_item.ndig;
	assign aligned = in_item.bcd << {gap, 2'b00};

	assign take      = busy_q && out_ready;
	assign last      = (cnt_q == '0);
	assign in_ready  = !busy_q || (take && last);
	assign out_valid = busy_q;
	assign character = ascii_of_digit(dig_q[BCD_W-1 -: DIGIT_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			cnt_q  <= in_item.ndig - 4'd1;
		end else if (take) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	// Digit shift register, one nibble out per taken character
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dig_q <= aligned;
		end else if (take) begin
			dig_q <= dig_q << DIGIT_W;
		end
	end

	// Final character with nothing waiting leaves the stage empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		take && last && !in_valid |=> !busy_q)
		else $error("serializer did not drain after last character");

	// A taken middle character steps the count down by one
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last |=> busy_q && (cnt_q == $past(cnt_q) - 4'd1))
		else $error("serializer count did not step");

	// Count never beyond the longest string
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q < NDIG_MAX))
		else $error("serializer count out of range");

	// Only digit characters leave the block
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ((character >= 7'h30 && character <= 7'h39) ||
			(character >= 7'h61 && character <= 7'h66)))
		else $error("non-digit character");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import bta_pkg::*;

	// Codes the block takes but formats nothing for
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 480;

	// One expected character on the output stream
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_exp_t;

	// Directed row: text holds the expected string right-justified when typed is set
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
		logic               typed;
		logic [79:0]        text;
	} stim_row_t;

	localparam int N_ROWS = 23;
	localparam stim_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
		'{OP_BYTE_DEC,  32'd0,          1'b1, "000"},
		'{OP_BYTE_DEC,  32'd255,        1'b1, "255"},
		'{OP_BYTE_DEC,  32'hFFFF_FF00,  1'b1, "000"},
		'{OP_BYTE_DEC,  32'd100,        1'b0, 80'd0},
		'{OP_WORD_DEC,  32'd0,          1'b1, "00000"},
		'{OP_WORD_DEC,  32'd65535,      1'b1, "65535"},
		'{OP_WORD_DEC,  32'hABCD_0000,  1'b1, "00000"},
		'{OP_WORD_DEC,  32'd10000,      1'b0, 80'd0},
		'{OP_DWORD_DEC, 32'd0,          1'b1, "0000000000"},
		'{OP_DWORD_DEC, 32'hFFFF_FFFF,  1'b1, "4294967295"},
		'{OP_DWORD_DEC, 32'd1000000000, 1'b0, 80'd0},
		'{OP_DWORD_DEC, 32'h8000_0000,  1'b0, 80'd0},
		'{OP_DWORD_DEC, 32'd9,          1'b0, 80'd0},
		'{OP_BYTE_HEX,  32'h0000_00FF,  1'b1, "ff"},
		'{OP_BYTE_HEX,  32'h1234_5600,  1'b1, "00"},
		'{OP_BYTE_HEX,  32'h0000_000A,  1'b0, 80'd0},
		'{OP_WORD_HEX,  32'h0000_ABCD,  1'b1, "abcd"},
		'{OP_WORD_HEX,  32'hFFFF_0000,  1'b1, "0000"},
		'{OP_DWORD_HEX, 32'h0123_4567,  1'b1, "01234567"},
		'{OP_DWORD_HEX, 32'h89AB_CDEF,  1'b1, "89abcdef"},
		'{OP_DWORD_HEX, 32'hFFFF_FFFF,  1'b1, "ffffffff"},
		'{OP_RSVD_6,    32'hFFFF_FFFF,  1'b1, 80'd0},
		'{OP_RSVD_7,    32'h0000_0000,  1'b1, 80'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire logic   s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] value
	logic [2:0]  s_axis_tuser = '0;   // [2:0] op
	wire logic   m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire logic [7:0] m_axis_tdata;    // [6:0] character, [7] zero
	wire logic   m_axis_tlast;

	char_exp_t pending_chars [$];
	int        fail_count = 0;
	int        idle_cycles = 0;
	logic      quiet = 1'b0;       // no idling on either side
	logic      hold_req = 1'b0;    // receiver holds off for a long stretch

	binary_to_ascii_digits u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int string_length(input logic [OP_W-1:0] op);
		case (op)
			OP_BYTE_DEC:  return 3;
			OP_WORD_DEC:  return 5;
			OP_DWORD_DEC: return 10;
			OP_BYTE_HEX:  return 2;
			OP_WORD_HEX:  return 4;
			OP_DWORD_HEX: return 8;
			default:      return 0;
		endcase
	endfunction

	// Expected digit string of one item, most significant digit first
	function automatic void format_digits(input logic [OP_W-1:0] op,
			input logic [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] radix;
		logic [DIGIT_W-1:0] digit [DIGITS_MAX];
		char_exp_t          c;
		int                 n;
		n = string_length(op);
		case (op)
			OP_BYTE_DEC, OP_BYTE_HEX: v = {24'h0, value[7:0]};
			OP_WORD_DEC, OP_WORD_HEX: v = {16'h0, value[15:0]};
			default:                  v = value;
		endcase
		radix = (op == OP_BYTE_HEX || op == OP_WORD_HEX || op == OP_DWORD_HEX) ? 16 : 10;
		for (int i = n - 1; i >= 0; i--) begin
			digit[i] = DIGIT_W'(v % radix);
			v = v / radix;
		end
		for (int i = 0; i < n; i++) begin
			c.ch   = (digit[i] < 10) ? 7'h30 + CHAR_W'(digit[i])
			                         : 7'h61 + CHAR_W'(digit[i]) - 7'd10;
			c.last = (i == n - 1);
			pending_chars.push_back(c);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	// Offer one item and hold it until taken, then record what it should give
	task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
			input logic typed, input logic [79:0] text);
		char_exp_t c;
		int        n;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		if (typed) begin
			n = string_length(op);
			for (int i = n - 1; i >= 0; i--) begin
				c.ch   = text[i*8 +: CHAR_W];
				c.last = (i == 0);
				pending_chars.push_back(c);
			end
		end else begin
			format_digits(op, value);
		end
	endtask

	// Random gap before an item
	task automatic sender_gap();
		if (!quiet && $urandom_range(99) < 13) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Sender stops until every character owed has come out
	task automatic drain_pause();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req <= 1'b0;
			end
			m_axis_tready <= quiet || ($urandom_range(99) >= 13);
		end
	end

	// Output check against the oldest expected character
	always @(posedge clk) begin : check_out
		char_exp_t c;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%h last %b",
					m_axis_tdata[6:0], m_axis_tlast));
			end else begin
				c = pending_chars.pop_front();
				if (m_axis_tdata[6:0] !== c.ch) begin
					report_mismatch($sformatf("character 0x%h, expected 0x%h",
						m_axis_tdata[6:0], c.ch));
				end
				if (m_axis_tlast !== c.last) begin
					report_mismatch($sformatf("last %b, expected %b", m_axis_tlast, c.last));
				end
			end
		end
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] tens;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: extremes, masking of high bits, every code
		for (int r = 0; r < N_ROWS; r++) begin
			sender_gap();
			send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].value,
				DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].text);
		end
		drain_pause();

		// Random items
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == 100) hold_req <= 1'b1;
			if (k == 200) quiet <= 1'b1;
			if (k == 280) quiet <= 1'b0;
			if (k == 350) drain_pause();
			if ($urandom_range(99) < 6) begin
				op = $urandom_range(1) ? OP_RSVD_6 : OP_RSVD_7;
			end else begin
				op = OP_W'($urandom_range(5));
			end
			case ($urandom_range(3))
				0: value = $urandom;
				1: value = $urandom >> $urandom_range(31);
				2: begin
					// around a power of ten
					tens = 1;
					repeat ($urandom_range(9)) tens = tens * 10;
					value = tens + $urandom_range(2) - 1;
				end
				default: value = $urandom_range(1) ? {16'($urandom), 16'h0000}
				                                   : {16'($urandom), 16'hFFFF};
			endcase
			sender_gap();
			send_item(op, value, 1'b0, 80'd0);
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		// Wait for the tail, then for anything still in the pipeline
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/bta_pkg.sv
hw/rtl/bta_front.sv
hw/rtl/bta_dabble_stage.sv
hw/rtl/bta_serializer.sv
hw/rtl/binary_to_ascii_digits.sv
tb/tb_top.sv
